// File: hw/rtl/wavp16_pkg.sv
// Shared types and constants for the PCM16 WAV stream parser.
package wavp16_pkg;

  // Chunk tags as they appear after four little-endian bytes are gathered.
  localparam logic [31:0] TAG_RIFF = 32'h4646_4952;
  localparam logic [31:0] TAG_WAVE = 32'h4556_4157;
  localparam logic [31:0] TAG_FMT  = 32'h2074_6D66;
  localparam logic [31:0] TAG_DATA = 32'h6174_6164;

  localparam logic [31:0] FMT_BODY_BYTES = 32'd16;
  localparam logic [15:0] FMT_CODE_PCM   = 16'd1;
  localparam logic [15:0] PCM_BITS       = 16'd16;
  localparam logic [15:0] CH_MONO        = 16'd1;
  localparam logic [15:0] CH_STEREO      = 16'd2;
  localparam logic [31:0] MONO_FRAME     = 32'd2;
  localparam logic [31:0] STEREO_FRAME   = 32'd4;

  // Fmt body offsets of the last byte of each captured field.
  localparam logic [3:0] FMT_IDX_CODE = 4'd1;
  localparam logic [3:0] FMT_IDX_CHAN = 4'd3;
  localparam logic [3:0] FMT_IDX_BITS = 4'd15;

  localparam logic [2:0] ST_SAMPLE    = 3'd0;
  localparam logic [2:0] ST_DONE_OK   = 3'd1;
  localparam logic [2:0] ST_BAD_TAG   = 3'd2;
  localparam logic [2:0] ST_BAD_FMT   = 3'd3;
  localparam logic [2:0] ST_UNSUPP    = 3'd4;
  localparam logic [2:0] ST_TRUNCATED = 3'd5;

  // Result queue: two entries of headroom so a word can push two results.
  localparam int unsigned QUEUE_AW    = 2;
  localparam int unsigned QUEUE_DEPTH = 1 << QUEUE_AW;

  typedef enum logic [3:0] {
    PH_RIFF     = 4'd0,
    PH_RSIZE    = 4'd1,
    PH_WAVE     = 4'd2,
    PH_ID       = 4'd3,
    PH_SZ_FMT   = 4'd4,
    PH_SZ_DATA  = 4'd5,
    PH_SZ_OTHER = 4'd6,
    PH_FMT      = 4'd7,
    PH_SKIP     = 4'd8,
    PH_DATA     = 4'd9,
    PH_DONE     = 4'd10
  } phase_t;

  typedef struct packed {
    logic signed [16:0] sample_value;
    logic [2:0]         status;
    logic               last;
  } result_t;

endpackage

// File: hw/rtl/wav_pcm16_to_mono_parser_core.sv
// Streaming RIFF/WAVE PCM16 parser that turns a byte stream into mono Q1.16 samples.
//
// Input channel: one file byte a word (in_byte, end_of_file on the last byte),
// taken when in_valid is high and in_stall is low. Output channel: one result
// a word (sample_value, status, last), taken when out_valid is high and
// out_stall is low. Status 0 is a sample; any other status is the single final
// word of a file and carries last = 1. On an error status the consumer drops
// the samples of that file.
// Each byte is parsed in the cycle it is taken and its results are written
// into a four-entry result queue, which offers them in order. One byte is
// accepted every cycle while in_stall is low; a byte can push up to two
// results (a sample followed by the final status), and in_stall rises while the
// queue has fewer than two free entries.
// When the receiver stalls, the queue fills and then the input is stalled; no
// result is lost or reordered.
// Synchronous reset empties the queue and puts the parser back to expecting the
// RIFF tag. The end-of-file byte does the same to the parser state, so the next
// file can follow directly.
module wav_pcm16_to_mono_parser_core (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [7:0]         in_byte,
  input  logic               end_of_file,
  output logic               out_valid,
  input  logic               out_stall,
  output logic signed [16:0] sample_value,
  output logic [2:0]         status,
  output logic               last
);

  wavp16_pkg::phase_t phase, phase_next;
  logic [31:0] bytes_left, bytes_left_next;
  logic [31:0] word_shift, word_shift_next;
  logic        fmt_pcm, fmt_pcm_next;
  logic        ch_mono, ch_mono_next;
  logic        ch_stereo, ch_stereo_next;
  logic        bits16, bits16_next;
  logic        format_seen, format_seen_next;
  logic [3:0]  fmt_index, fmt_index_next;
  logic [1:0]  byte_in_frame, byte_in_frame_next;
  logic [15:0] left_sample, left_sample_next;
  logic        pad_pending, pad_pending_next;
  logic        any_sample, any_sample_next;

  logic        in_acc;
  logic [31:0] ws_shifted;
  logic [1:0]  bif_inc;
  logic [31:0] bl_dec;
  logic        pad_after;
  logic [31:0] frame_len_bytes;
  logic        samp_fire;
  logic signed [16:0] samp_val;
  logic        fin_fire;
  logic [2:0]  fin_status;

  wavp16_pkg::result_t queue [wavp16_pkg::QUEUE_DEPTH];
  logic [wavp16_pkg::QUEUE_AW-1:0] wr_ptr, rd_ptr;
  logic [wavp16_pkg::QUEUE_AW:0]   count;
  logic [1:0]                      push_cnt;
  logic                            pop;
  wavp16_pkg::result_t             first_res, second_res;

  assign in_acc     = in_valid && !in_stall;
  assign ws_shifted = {in_byte, word_shift[31:8]};
  assign bif_inc    = byte_in_frame + 2'd1;
  assign bl_dec     = (bytes_left != 32'd0) ? bytes_left - 32'd1 : bytes_left;
  assign frame_len_bytes = ch_mono ? wavp16_pkg::MONO_FRAME : wavp16_pkg::STEREO_FRAME;

  always_comb begin
    phase_next         = phase;
    bytes_left_next    = bytes_left;
    word_shift_next    = word_shift;
    fmt_pcm_next       = fmt_pcm;
    ch_mono_next       = ch_mono;
    ch_stereo_next     = ch_stereo;
    bits16_next        = bits16;
    format_seen_next   = format_seen;
    fmt_index_next     = fmt_index;
    byte_in_frame_next = byte_in_frame;
    left_sample_next   = left_sample;
    pad_pending_next   = pad_pending;
    any_sample_next    = any_sample;
    samp_fire          = 1'b0;
    samp_val           = '0;
    fin_fire           = 1'b0;
    fin_status         = wavp16_pkg::ST_DONE_OK;
    pad_after          = 1'b0;

    if (in_acc) begin
      if (phase inside {wavp16_pkg::PH_RIFF, wavp16_pkg::PH_RSIZE, wavp16_pkg::PH_WAVE,
                        wavp16_pkg::PH_ID, wavp16_pkg::PH_SZ_FMT, wavp16_pkg::PH_SZ_DATA,
                        wavp16_pkg::PH_SZ_OTHER}) begin
        word_shift_next    = ws_shifted;
        byte_in_frame_next = bif_inc;
        if (bif_inc == 2'd0) begin
          case (phase)
            wavp16_pkg::PH_RIFF: begin
              if (ws_shifted != wavp16_pkg::TAG_RIFF) begin
                fin_fire   = 1'b1;
                fin_status = wavp16_pkg::ST_BAD_TAG;
              end else begin
                phase_next = wavp16_pkg::PH_RSIZE;
              end
            end
            wavp16_pkg::PH_RSIZE: begin
              phase_next = wavp16_pkg::PH_WAVE;
            end
            wavp16_pkg::PH_WAVE: begin
              if (ws_shifted != wavp16_pkg::TAG_WAVE) begin
                fin_fire   = 1'b1;
                fin_status = wavp16_pkg::ST_BAD_TAG;
              end else begin
                phase_next = wavp16_pkg::PH_ID;
              end
            end
            wavp16_pkg::PH_ID: begin
              if (ws_shifted == wavp16_pkg::TAG_FMT) begin
                phase_next = wavp16_pkg::PH_SZ_FMT;
              end else if (ws_shifted == wavp16_pkg::TAG_DATA) begin
                phase_next = wavp16_pkg::PH_SZ_DATA;
              end else begin
                phase_next = wavp16_pkg::PH_SZ_OTHER;
              end
            end
            wavp16_pkg::PH_SZ_FMT: begin
              if (ws_shifted < wavp16_pkg::FMT_BODY_BYTES) begin
                fin_fire   = 1'b1;
                fin_status = wavp16_pkg::ST_BAD_FMT;
              end else begin
                bytes_left_next  = ws_shifted - wavp16_pkg::FMT_BODY_BYTES;
                pad_pending_next = ws_shifted[0];
                fmt_index_next   = 4'd0;
                phase_next       = wavp16_pkg::PH_FMT;
              end
            end
            wavp16_pkg::PH_SZ_OTHER: begin
              // An odd size always leaves a pad byte, so only size zero skips nothing.
              bytes_left_next  = ws_shifted;
              pad_pending_next = ws_shifted[0];
              phase_next = (ws_shifted == 32'd0) ? wavp16_pkg::PH_ID : wavp16_pkg::PH_SKIP;
            end
            default: begin
              bytes_left_next = ws_shifted;
              if (!format_seen) begin
                fin_fire   = 1'b1;
                fin_status = wavp16_pkg::ST_BAD_FMT;
              end else if (!fmt_pcm || !bits16 || !(ch_mono || ch_stereo)) begin
                fin_fire   = 1'b1;
                fin_status = wavp16_pkg::ST_UNSUPP;
              end else if (ws_shifted < frame_len_bytes) begin
                fin_fire   = 1'b1;
                fin_status = wavp16_pkg::ST_TRUNCATED;
              end else begin
                byte_in_frame_next = 2'd0;
                any_sample_next    = 1'b0;
                phase_next         = wavp16_pkg::PH_DATA;
              end
            end
          endcase
        end
      end else begin
        case (phase)
          wavp16_pkg::PH_FMT: begin
            word_shift_next = ws_shifted;
            if (fmt_index == wavp16_pkg::FMT_IDX_CODE) begin
              fmt_pcm_next = (ws_shifted[31:16] == wavp16_pkg::FMT_CODE_PCM);
            end else if (fmt_index == wavp16_pkg::FMT_IDX_CHAN) begin
              ch_mono_next   = (ws_shifted[31:16] == wavp16_pkg::CH_MONO);
              ch_stereo_next = (ws_shifted[31:16] == wavp16_pkg::CH_STEREO);
            end else if (fmt_index == wavp16_pkg::FMT_IDX_BITS) begin
              bits16_next      = (ws_shifted[31:16] == wavp16_pkg::PCM_BITS);
              format_seen_next = 1'b1;
              phase_next = (bytes_left == 32'd0 && !pad_pending) ? wavp16_pkg::PH_ID
                                                                 : wavp16_pkg::PH_SKIP;
            end
            fmt_index_next = fmt_index + 4'd1;
          end
          wavp16_pkg::PH_SKIP: begin
            pad_after = (bytes_left != 32'd0) ? pad_pending : 1'b0;
            bytes_left_next  = bl_dec;
            pad_pending_next = pad_after;
            if (bl_dec == 32'd0 && !pad_after) begin
              phase_next = wavp16_pkg::PH_ID;
            end
          end
          wavp16_pkg::PH_DATA: begin
            bytes_left_next    = bl_dec;
            word_shift_next    = ws_shifted;
            byte_in_frame_next = bif_inc;
            if (ch_mono) begin
              if (bif_inc == 2'd2) begin
                samp_fire          = 1'b1;
                samp_val           = {ws_shifted[31:16], 1'b0};
                byte_in_frame_next = 2'd0;
                any_sample_next    = 1'b1;
              end
            end else if (bif_inc == 2'd2) begin
              left_sample_next = ws_shifted[31:16];
            end else if (bif_inc == 2'd0) begin
              samp_fire       = 1'b1;
              samp_val        = $signed({left_sample[15], left_sample})
                              + $signed({ws_shifted[31], ws_shifted[31:16]});
              any_sample_next = 1'b1;
            end
            if (bl_dec == 32'd0) begin
              fin_fire   = 1'b1;
              fin_status = any_sample_next ? wavp16_pkg::ST_DONE_OK
                                           : wavp16_pkg::ST_TRUNCATED;
            end
          end
          default: ;
        endcase
      end

      if (fin_fire) begin
        phase_next = wavp16_pkg::PH_DONE;
      end

      // End of file closes any open file with a truncation status.
      if (end_of_file) begin
        if (!fin_fire && phase_next != wavp16_pkg::PH_DONE) begin
          fin_fire   = 1'b1;
          fin_status = wavp16_pkg::ST_TRUNCATED;
        end
        phase_next         = wavp16_pkg::PH_RIFF;
        bytes_left_next    = '0;
        word_shift_next    = '0;
        fmt_pcm_next       = 1'b0;
        ch_mono_next       = 1'b0;
        ch_stereo_next     = 1'b0;
        bits16_next        = 1'b0;
        format_seen_next   = 1'b0;
        fmt_index_next     = '0;
        byte_in_frame_next = '0;
        left_sample_next   = '0;
        pad_pending_next   = 1'b0;
        any_sample_next    = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase         <= wavp16_pkg::PH_RIFF;
      bytes_left    <= '0;
      word_shift    <= '0;
      fmt_pcm       <= 1'b0;
      ch_mono       <= 1'b0;
      ch_stereo     <= 1'b0;
      bits16        <= 1'b0;
      format_seen   <= 1'b0;
      fmt_index     <= '0;
      byte_in_frame <= '0;
      left_sample   <= '0;
      pad_pending   <= 1'b0;
      any_sample    <= 1'b0;
    end else begin
      phase         <= phase_next;
      bytes_left    <= bytes_left_next;
      word_shift    <= word_shift_next;
      fmt_pcm       <= fmt_pcm_next;
      ch_mono       <= ch_mono_next;
      ch_stereo     <= ch_stereo_next;
      bits16        <= bits16_next;
      format_seen   <= format_seen_next;
      fmt_index     <= fmt_index_next;
      byte_in_frame <= byte_in_frame_next;
      left_sample   <= left_sample_next;
      pad_pending   <= pad_pending_next;
      any_sample    <= any_sample_next;
    end
  end

  // The sample, when present, always goes ahead of the final status.
  always_comb begin
    second_res.sample_value = '0;
    second_res.status       = fin_status;
    second_res.last         = 1'b1;
    if (samp_fire) begin
      first_res.sample_value = samp_val;
      first_res.status       = wavp16_pkg::ST_SAMPLE;
      first_res.last         = 1'b0;
    end else begin
      first_res = second_res;
    end
  end

  assign push_cnt  = {1'b0, samp_fire} + {1'b0, fin_fire};
  assign pop       = out_valid && !out_stall;
  assign out_valid = (count != '0);
  assign in_stall  = (count > (wavp16_pkg::QUEUE_AW + 1)'(wavp16_pkg::QUEUE_DEPTH - 2));

  assign sample_value = queue[rd_ptr].sample_value;
  assign status       = queue[rd_ptr].status;
  assign last         = queue[rd_ptr].last;

  always_ff @(posedge clk) begin
    if (push_cnt != 2'd0) begin
      queue[wr_ptr] <= first_res;
    end
    if (push_cnt == 2'd2) begin
      queue[wr_ptr + 1'b1] <= second_res;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      wr_ptr <= wr_ptr + push_cnt[wavp16_pkg::QUEUE_AW-1:0];
      rd_ptr <= rd_ptr + {{(wavp16_pkg::QUEUE_AW-1){1'b0}}, pop};
      count  <= count + {{(wavp16_pkg::QUEUE_AW-1){1'b0}}, push_cnt}
                      - {{wavp16_pkg::QUEUE_AW{1'b0}}, pop};
    end
  end

  a_queue_bound: assert property (@(posedge clk) disable iff (rst)
    count <= (wavp16_pkg::QUEUE_AW + 1)'(wavp16_pkg::QUEUE_DEPTH))
    else $error("result queue overflow");

  a_last_on_status: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (last == (status != wavp16_pkg::ST_SAMPLE)))
    else $error("last flag does not match status");

  a_eof_rearms: assert property (@(posedge clk) disable iff (rst)
    in_acc && end_of_file |=> phase == wavp16_pkg::PH_RIFF)
    else $error("parser not rearmed after end of file");

  a_eof_closes: assert property (@(posedge clk) disable iff (rst)
    in_acc && end_of_file && phase != wavp16_pkg::PH_DONE |-> fin_fire)
    else $error("open file ended without a final status");

endmodule
